// File: rtl/core/sme_pkg.sv
package sme_pkg;

    // ascii codes of the mappings text
    localparam logic [6:0] CHAR_COMMA = 7'h2C;
    localparam logic [6:0] CHAR_SEMI  = 7'h3B;
    localparam logic [6:0] CHAR_PLUS  = 7'h2B;
    localparam logic [6:0] CHAR_SLASH = 7'h2F;
    localparam logic [6:0] CHAR_UPPER = 7'h41;
    localparam logic [6:0] CHAR_LOWER = 7'h61;
    localparam logic [6:0] CHAR_DIGIT = 7'h30;

    // vlq digit layout
    localparam int unsigned GROUP_BITS = 5;
    localparam logic [5:0]  B64_PLUS   = 6'd62;

    typedef enum logic [1:0] {
        CH_COMMA,
        CH_SEMI,
        CH_DIGIT
    } char_sel_t;

    // controller to datapath
    typedef struct packed {
        logic      capture;
        logic      load;
        logic      emit;
        char_sel_t sel;
        logic      last;
        logic      next_field;
    } sme_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic mode;
        logic src_valid;
        logic need_comma;
        logic more;
        logic field_last;
        logic out_ready;
    } sme_sts_t;

    function automatic logic [6:0] b64_char(input logic [5:0] v);
        logic [6:0] c;
        if (v < 6'd26) begin
            c = CHAR_UPPER + 7'(v);
        end else if (v < 6'd52) begin
            c = CHAR_LOWER + 7'(v) - 7'd26;
        end else if (v < B64_PLUS) begin
            c = CHAR_DIGIT + 7'(v) - 7'd52;
        end else if (v == B64_PLUS) begin
            c = CHAR_PLUS;
        end else begin
            c = CHAR_SLASH;
        end
        return c;
    endfunction

endpackage

// File: rtl/core/sme_ctrl.sv
module sme_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  sme_pkg::sme_sts_t sts,
    output sme_pkg::sme_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_COMMA,
        ST_LOAD,
        ST_DIGIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.sel        = sme_pkg::CH_DIGIT;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (sts.mode) begin
                    // end of generated line: one semicolon
                    if (sts.out_ready) begin
                        cmd.emit   = 1'b1;
                        cmd.sel    = sme_pkg::CH_SEMI;
                        cmd.last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else if (!sts.src_valid) begin
                    state_next = ST_IDLE;
                end else if (sts.need_comma) begin
                    state_next = ST_COMMA;
                end else begin
                    state_next = ST_LOAD;
                end
            end
            ST_COMMA: begin
                if (sts.out_ready) begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = sme_pkg::CH_COMMA;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = ST_DIGIT;
            end
            ST_DIGIT: begin
                if (sts.out_ready) begin
                    cmd.emit = 1'b1;
                    cmd.sel  = sme_pkg::CH_DIGIT;
                    if (!sts.more) begin
                        if (sts.field_last) begin
                            cmd.last   = 1'b1;
                            state_next = ST_IDLE;
                        end else begin
                            cmd.next_field = 1'b1;
                            state_next     = ST_LOAD;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/sme_datapath.sv
module sme_datapath #(
    parameter int unsigned COORD_BITS  = 20,
    parameter int unsigned SOURCE_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  sme_pkg::sme_cmd_t      cmd,
    output sme_pkg::sme_sts_t      sts,
    input  logic                   in_mode,
    input  logic                   in_src_valid,
    input  logic [COORD_BITS-1:0]  in_gen_column,
    input  logic [SOURCE_BITS-1:0] in_source_index,
    input  logic [COORD_BITS-1:0]  in_orig_line,
    input  logic [COORD_BITS-1:0]  in_orig_column,
    output logic                   out_valid,
    output logic [6:0]             out_char,
    output logic                   out_last,
    input  logic                   out_ready
);

    localparam int unsigned DW = (COORD_BITS > SOURCE_BITS) ? COORD_BITS : SOURCE_BITS;
    localparam int unsigned FW = DW + 1;

    typedef enum logic [1:0] {
        F_GEN,
        F_SRC,
        F_OLINE,
        F_OCOL
    } field_t;

    // captured word
    logic                   mode_reg;
    logic                   src_valid_reg;
    logic [COORD_BITS-1:0]  gen_reg;
    logic [SOURCE_BITS-1:0] src_reg;
    logic [COORD_BITS-1:0]  oline_reg;
    logic [COORD_BITS-1:0]  ocol_reg;

    // running state
    logic [COORD_BITS-1:0]  prev_gen_reg;
    logic [SOURCE_BITS-1:0] prev_src_reg;
    logic [COORD_BITS-1:0]  prev_oline_reg;
    logic [COORD_BITS-1:0]  prev_ocol_reg;
    logic                   need_comma_reg;
    field_t                 fidx_reg;
    logic [FW-1:0]          folded_reg;

    // output word
    logic                   out_valid_reg;
    logic [6:0]             out_char_reg;
    logic                   out_last_reg;

    logic [DW-1:0]          now_val;
    logic [DW-1:0]          old_val;
    logic [FW-1:0]          folded_next;
    logic                   more;
    logic [6:0]             char_next;
    logic                   out_free;

    assign more     = |folded_reg[FW-1:sme_pkg::GROUP_BITS];
    assign out_free = !out_valid_reg || out_ready;

    always_comb begin
        case (fidx_reg)
            F_GEN: begin
                now_val = DW'(gen_reg);
                old_val = DW'(prev_gen_reg);
            end
            F_SRC: begin
                now_val = DW'(src_reg);
                old_val = DW'(prev_src_reg);
            end
            F_OLINE: begin
                now_val = DW'(oline_reg);
                old_val = DW'(prev_oline_reg);
            end
            default: begin
                now_val = DW'(ocol_reg);
                old_val = DW'(prev_ocol_reg);
            end
        endcase
        // sign fold: magnitude above, sign in bit 0
        if (now_val >= old_val) begin
            folded_next = {now_val - old_val, 1'b0};
        end else begin
            folded_next = {old_val - now_val, 1'b1};
        end
    end

    always_comb begin
        unique case (cmd.sel)
            sme_pkg::CH_COMMA: char_next = sme_pkg::CHAR_COMMA;
            sme_pkg::CH_SEMI:  char_next = sme_pkg::CHAR_SEMI;
            sme_pkg::CH_DIGIT: char_next = sme_pkg::b64_char({more, folded_reg[4:0]});
            default:           char_next = sme_pkg::CHAR_SEMI;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg      <= in_mode;
            src_valid_reg <= in_src_valid;
            gen_reg       <= in_gen_column;
            src_reg       <= in_source_index;
            oline_reg     <= in_orig_line;
            ocol_reg      <= in_orig_column;
        end
        if (cmd.load) begin
            folded_reg <= folded_next;
        end else if (cmd.emit && cmd.sel == sme_pkg::CH_DIGIT) begin
            folded_reg <= folded_reg >> sme_pkg::GROUP_BITS;
        end
        if (cmd.emit) begin
            out_char_reg <= char_next;
            out_last_reg <= cmd.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_gen_reg   <= '0;
            prev_src_reg   <= '0;
            prev_oline_reg <= '0;
            prev_ocol_reg  <= '0;
            need_comma_reg <= 1'b0;
            fidx_reg       <= F_GEN;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.capture) begin
                fidx_reg <= F_GEN;
            end else if (cmd.next_field) begin
                fidx_reg <= field_t'(fidx_reg + 2'd1);
            end
            // the old value is consumed in the load cycle, so commit it there
            if (cmd.load) begin
                need_comma_reg <= 1'b1;
                case (fidx_reg)
                    F_GEN:   prev_gen_reg   <= gen_reg;
                    F_SRC:   prev_src_reg   <= src_reg;
                    F_OLINE: prev_oline_reg <= oline_reg;
                    default: prev_ocol_reg  <= ocol_reg;
                endcase
            end
            if (cmd.emit && cmd.sel == sme_pkg::CH_SEMI) begin
                need_comma_reg <= 1'b0;
                prev_gen_reg   <= '0;
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.mode       = mode_reg;
    assign sts.src_valid  = src_valid_reg;
    assign sts.need_comma = need_comma_reg;
    assign sts.more       = more;
    assign sts.field_last = (fidx_reg == F_OCOL);
    assign sts.out_ready  = out_free;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

endmodule

// File: rtl/core/source_map_segment_encoder.sv
// channel   dir  handshake             payload
// s_axis    in   tvalid/tready         tdata: gen_column, source_index, orig_line,
//                                      orig_column; tuser: mode, source_valid
// m_axis    out  tvalid/tready/tlast   tdata: char_code; tlast: last
//
// one word in at a time; an end-of-line word sends one semicolon, a word without a
// source sends nothing, a segment an optional comma, then per field a load and its
// vlq digits, through the one-character-per-cycle output register (while it is not
// stalled) and the shared delta/fold unit
// output stalls hold the sequencer in place; input is taken only when idle
// reset (aresetn low, synchronous) clears previous values and comma flag
module source_map_segment_encoder #(
    parameter int unsigned COORD_BITS  = 20,
    parameter int unsigned SOURCE_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata from bit 0: gen_column, source_index, orig_line, orig_column, zero pad
    input  logic [((3*COORD_BITS+SOURCE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // tuser from bit 0: mode, source_valid
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata from bit 0: char_code, zero pad
    output logic [7:0]            m_axis_tdata,
    output logic                  m_axis_tlast
);

    // field offsets inside s_axis_tdata
    localparam int unsigned SRC_LO   = COORD_BITS;
    localparam int unsigned OLINE_LO = COORD_BITS + SOURCE_BITS;
    localparam int unsigned OCOL_LO  = 2*COORD_BITS + SOURCE_BITS;

    sme_pkg::sme_cmd_t cmd;
    sme_pkg::sme_sts_t sts;
    logic [6:0]        char_code;

    sme_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sme_datapath #(
        .COORD_BITS  (COORD_BITS),
        .SOURCE_BITS (SOURCE_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .in_mode         (s_axis_tuser[0]),
        .in_src_valid    (s_axis_tuser[1]),
        .in_gen_column   (s_axis_tdata[COORD_BITS-1:0]),
        .in_source_index (s_axis_tdata[SRC_LO +: SOURCE_BITS]),
        .in_orig_line    (s_axis_tdata[OLINE_LO +: COORD_BITS]),
        .in_orig_column  (s_axis_tdata[OCOL_LO +: COORD_BITS]),
        .out_valid       (m_axis_tvalid),
        .out_char        (char_code),
        .out_last        (m_axis_tlast),
        .out_ready       (m_axis_tready)
    );

    assign m_axis_tdata = {1'b0, char_code};

    // a character is only loaded when the output register can take it
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.out_ready)
        else $error("character loaded into a full output register");

    // an accepted word closes the input until its work is done
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input reopened right after accept");

    // the final character of a word returns the block to idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && cmd.last) |=> s_axis_tready)
        else $error("not idle after final character");

    // a semicolon only ever ends a word
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[6:0] == sme_pkg::CHAR_SEMI) |-> m_axis_tlast)
        else $error("semicolon without tlast");

endmodule

// File: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned COORD_BITS  = 20;
    localparam int unsigned SOURCE_BITS = 16;
    localparam int unsigned TDATA_BITS  = ((3*COORD_BITS+SOURCE_BITS+7)/8)*8;

    // item kinds carried in tuser bit 0
    localparam logic MODE_SEGMENT  = 1'b0;
    localparam logic MODE_LINE_END = 1'b1;

    localparam int RANDOM_WORDS = 370;
    // settle time kept after the last owed character has been checked
    localparam int DRAIN_CYCLES = 40;
    // watchdog limit for a stretch with no handshake on either side
    localparam int IDLE_LIMIT   = 2000;

    typedef struct {
        logic [6:0] code;
        logic       last;
    } map_char_t;

    // predicts the mappings text and keeps the characters still owed by the block
    class mappings_board;
        map_char_t             pending_chars[$];
        logic [COORD_BITS-1:0]  last_gen_col;
        logic [SOURCE_BITS-1:0] last_src_idx;
        logic [COORD_BITS-1:0]  last_orig_line;
        logic [COORD_BITS-1:0]  last_orig_col;
        bit                     comma_due;
        string                  alphabet;
        int                     errors;
        int                     chars_seen;
        int                     n_segments;
        int                     n_skipped;
        int                     n_line_ends;

        function new();
            alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
            last_gen_col   = '0;
            last_src_idx   = '0;
            last_orig_line = '0;
            last_orig_col  = '0;
            comma_due      = 0;
            errors         = 0;
            chars_seen     = 0;
            n_segments     = 0;
            n_skipped      = 0;
            n_line_ends    = 0;
        endfunction

        function void push_char(logic [6:0] code);
            map_char_t c;
            c.code = code;
            c.last = 1'b0;
            pending_chars.insert(pending_chars.size(), c);
        endfunction

        // sign-folded delta, low five bits first, bit 5 flags another digit
        function void append_vlq(logic [31:0] now, logic [31:0] old);
            logic [31:0] folded;
            byte         ch;
            if (now >= old) begin
                folded = (now - old) << 1;
            end else begin
                folded = ((old - now) << 1) | 32'd1;
            end
            while (folded > 32'd31) begin
                ch = alphabet[folded[4:0] | 5'd0 + 32];
                push_char(ch[6:0]);
                folded = folded >> 5;
            end
            ch = alphabet[folded[4:0]];
            push_char(ch[6:0]);
        endfunction

        function void take_word(logic mode, logic src_valid, logic [TDATA_BITS-1:0] data);
            logic [COORD_BITS-1:0]  gcol;
            logic [SOURCE_BITS-1:0] sidx;
            logic [COORD_BITS-1:0]  oline;
            logic [COORD_BITS-1:0]  ocol;
            gcol  = data[COORD_BITS-1:0];
            sidx  = data[COORD_BITS +: SOURCE_BITS];
            oline = data[COORD_BITS+SOURCE_BITS +: COORD_BITS];
            ocol  = data[2*COORD_BITS+SOURCE_BITS +: COORD_BITS];
            if (mode == MODE_LINE_END) begin
                n_line_ends++;
                push_char(sme_pkg::CHAR_SEMI);
                last_gen_col = '0;
                comma_due    = 0;
            end else if (!src_valid) begin
                n_skipped++;
                return;
            end else begin
                n_segments++;
                if (comma_due) begin
                    push_char(sme_pkg::CHAR_COMMA);
                end
                append_vlq(32'(gcol), 32'(last_gen_col));
                append_vlq(32'(sidx), 32'(last_src_idx));
                append_vlq(32'(oline), 32'(last_orig_line));
                append_vlq(32'(ocol), 32'(last_orig_col));
                last_gen_col   = gcol;
                last_src_idx   = sidx;
                last_orig_line = oline;
                last_orig_col  = ocol;
                comma_due      = 1;
            end
            pending_chars[pending_chars.size()-1].last = 1'b1;
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_char(logic [7:0] data, logic tlast);
            map_char_t want;
            chars_seen++;
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected char 0x%02h", data[6:0]));
            end else begin
                want = pending_chars.pop_front();
                if (data[6:0] !== want.code) begin
                    report_mismatch($sformatf("char_code 0x%02h, wanted 0x%02h",
                                              data[6:0], want.code));
                end
                if (tlast !== want.last) begin
                    report_mismatch($sformatf("last %b, wanted %b on char 0x%02h",
                                              tlast, want.last, want.code));
                end
            end
        endtask
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // from bit 0: gen_column, source_index, orig_line, orig_column, zero pad
    logic [TDATA_BITS-1:0] s_axis_tdata;
    // from bit 0: mode, source_valid
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // from bit 0: char_code, zero pad
    logic [7:0]            m_axis_tdata;
    logic                  m_axis_tlast;

    mappings_board sb = new();

    // sender burst bookkeeping
    int burst_left = 0;
    // receiver stall pattern: a style and how many cycles it lasts
    int rx_style   = 0;
    int rx_left    = 0;
    int rx_phase   = 0;
    int quiet      = 0;

    // last coordinates handed out, so random deltas stay near them
    logic [COORD_BITS-1:0]  near_gcol  = '0;
    logic [SOURCE_BITS-1:0] near_sidx  = '0;
    logic [COORD_BITS-1:0]  near_oline = '0;
    logic [COORD_BITS-1:0]  near_ocol  = '0;

    always #2ns aclk = ~aclk;

    source_map_segment_encoder #(
        .COORD_BITS (COORD_BITS),
        .SOURCE_BITS(SOURCE_BITS)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    // pack one segment into tdata, gen_column lowest
    function automatic logic [TDATA_BITS-1:0] pack_segment(
        logic [COORD_BITS-1:0] gcol, logic [SOURCE_BITS-1:0] sidx,
        logic [COORD_BITS-1:0] oline, logic [COORD_BITS-1:0] ocol);
        logic [TDATA_BITS-1:0] d;
        d = '0;
        d[COORD_BITS-1:0]                          = gcol;
        d[COORD_BITS +: SOURCE_BITS]               = sidx;
        d[COORD_BITS+SOURCE_BITS +: COORD_BITS]    = oline;
        d[2*COORD_BITS+SOURCE_BITS +: COORD_BITS]  = ocol;
        return d;
    endfunction

    // mostly small steps around the previous value, sometimes the extremes
    function automatic logic [31:0] pick_near(logic [31:0] prev, int unsigned bits);
        logic [31:0] mask;
        logic [31:0] v;
        mask = (32'd1 << bits) - 32'd1;
        case ($urandom_range(0, 7))
            0, 1:    v = prev + $urandom_range(0, 40);
            2:       v = prev - $urandom_range(0, 40);
            3:       v = prev + $urandom_range(0, 3000);
            4:       v = $urandom;
            5:       v = '0;
            6:       v = mask;
            default: v = prev;
        endcase
        return v & mask;
    endfunction

    // hand one word to the block; bursts of random length with gaps between
    task automatic push_word(logic mode, logic src_valid, logic [TDATA_BITS-1:0] data);
        int gap;
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(posedge aclk);
            // now and then a long burst with no idling at all
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= {src_valid, mode};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sb.take_word(mode, src_valid, data);
        burst_left--;
    endtask

    task automatic push_segment(logic [COORD_BITS-1:0] gcol, logic [SOURCE_BITS-1:0] sidx,
                                logic [COORD_BITS-1:0] oline, logic [COORD_BITS-1:0] ocol);
        push_word(MODE_SEGMENT, 1'b1, pack_segment(gcol, sidx, oline, ocol));
    endtask

    // line end with random junk in the ignored fields
    task automatic push_line_end(logic src_valid);
        push_word(MODE_LINE_END, src_valid,
                  pack_segment(20'($urandom), 16'($urandom), 20'($urandom), 20'($urandom)));
    endtask

    // stop sending until the block has handed back everything owed
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        burst_left = 0;
    endtask

    // receiver: take characters, then pick tready from the current stall style
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            sb.check_char(m_axis_tdata, m_axis_tlast);
        end
        if (rx_left == 0) begin
            rx_style = $urandom_range(0, 3);
            rx_left  = $urandom_range(32, 200);
        end
        rx_left--;
        rx_phase++;
        case (rx_style)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            2:       m_axis_tready <= (rx_phase % 5 != 0);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // watchdog: too long with no word moving on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= IDLE_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d chars still owed",
                         quiet, sb.pending_chars.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        int          roll;
        logic [31:0] g;
        logic [31:0] s;
        logic [31:0] l;
        logic [31:0] c;

        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        m_axis_tready <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero deltas from reset: four single 'A' digits, no comma yet
        push_segment('0, '0, '0, '0);
        // largest positive deltas, then largest negative ones
        push_segment('1, '1, '1, '1);
        push_segment('0, '0, '0, '0);
        // segment without a source leaves state alone and sends nothing
        push_word(MODE_SEGMENT, 1'b0, pack_segment('1, '1, '1, '1));
        push_line_end(1'b1);
        push_line_end(1'b0);
        // after a line end: no comma, gen column measured from zero
        push_segment(20'd15, 16'd15, 20'd15, 20'd15);
        // delta of +16 needs a second digit, -16 sets the sign bit
        push_segment(20'd31, 16'd31, 20'd31, 20'd31);
        push_segment(20'd15, 16'd15, 20'd15, 20'd15);
        push_segment(20'd15, 16'd15, 20'd15, 20'd15);
        // skipped segment right after a line end must not eat the comma state
        push_line_end(1'b1);
        push_word(MODE_SEGMENT, 1'b0, pack_segment(20'd7, 16'd7, 20'd7, 20'd7));
        push_segment(20'd1, 16'd1, 20'd1, 20'd1);
        // alternating bit patterns across every field, then top bit only and bottom bit only
        push_segment(20'hAAAAA, 16'hAAAA, 20'hAAAAA, 20'hAAAAA);
        push_segment(20'h55555, 16'h5555, 20'h55555, 20'h55555);
        push_segment(20'h80000, 16'h8000, 20'h80000, 20'h80000);
        push_segment(20'h00001, 16'h0001, 20'h00001, 20'h00001);
        push_line_end(1'b0);
        hold_until_drained();

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            roll = $urandom_range(0, 99);
            g = pick_near(32'(near_gcol), COORD_BITS);
            s = pick_near(32'(near_sidx), SOURCE_BITS);
            l = pick_near(32'(near_oline), COORD_BITS);
            c = pick_near(32'(near_ocol), COORD_BITS);
            if (roll < 12) begin
                push_line_end(1'($urandom));
                near_gcol = '0;
            end else if (roll < 20) begin
                push_word(MODE_SEGMENT, 1'b0, pack_segment(g[19:0], s[15:0], l[19:0], c[19:0]));
            end else begin
                push_segment(g[19:0], s[15:0], l[19:0], c[19:0]);
                near_gcol  = g[19:0];
                near_sidx  = s[15:0];
                near_oline = l[19:0];
                near_ocol  = c[19:0];
            end
            // let the block run dry now and then
            if (i % 120 == 119) begin
                hold_until_drained();
            end
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d segments, %0d skipped segments, %0d line ends",
                 sb.n_segments, sb.n_skipped, sb.n_line_ends);
        $display("checked %0d characters, %0d mismatches", sb.chars_seen, sb.errors);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
